// ===== hdl/cfwd_pkg.sv =====
// shared types and constants of the strided convolution block
// no dependencies
package cfwd_pkg;

  localparam int ROW_W     = 10;
  localparam int OUT_COL_W = 6;
  localparam int DATA_W    = 16;
  localparam int SUM_W     = 32;
  localparam int RES_DEPTH = 4;

  localparam logic [1:0] ACT_WEIGHT = 2'd0;
  localparam logic [1:0] ACT_BIAS   = 2'd1;
  localparam logic [1:0] ACT_PIXEL  = 2'd2;

  localparam logic [2:0] REG_ROWS     = 3'd0;
  localparam logic [2:0] REG_COLS     = 3'd1;
  localparam logic [2:0] REG_CHANS    = 3'd2;
  localparam logic [2:0] REG_KROWS    = 3'd3;
  localparam logic [2:0] REG_KCOLS    = 3'd4;
  localparam logic [2:0] REG_SROWS    = 3'd5;
  localparam logic [2:0] REG_SCOLS    = 3'd6;
  localparam logic [2:0] REG_FILTERS  = 3'd7;

  typedef enum logic [2:0] {
    K_WEIGHT = 3'b001,
    K_BIAS   = 3'b010,
    K_PIXEL  = 3'b100
  } kind_t;

  typedef struct packed {
    logic [10:0] rows;
    logic [6:0]  cols;
    logic [3:0]  chans;
    logic [2:0]  krows;
    logic [2:0]  kcols;
    logic [2:0]  srows;
    logic [2:0]  scols;
    logic [3:0]  filters;
  } cfg_t;

endpackage

// ===== hdl/conv2d_forward_top.sv =====
// top level of the strided multi-filter convolution: register port, front, queue, back
// depends on cfwd_pkg, cfwd_front, cfwd_queue, cfwd_back
//
// Load weights (action 0) and biases (action 1), then stream pixel samples
// (action 2) in raster order with channels innermost. The front accepts an item while
// the queue is not full; the back pops queued items while idle. For a pixel that
// completes a strided window the back runs filter_count * kernel_rows * kernel_cols
// * channel_count products on its single multiply-accumulate, through read, product
// and result-queue registers, holding while the result queue has no room. A
// two-entry queue lets the front keep taking items meanwhile. Results are held in
// a four-word output queue. The user must write registers over the APB port only
// while the block is idle; it is not enforced. Any write restarts the image position.
module conv2d_forward_top #(
  parameter int MAX_FILTERS    = 8,
  parameter int MAX_KERNEL     = 5,
  parameter int MAX_CHANNELS   = 8,
  parameter int MAX_IMAGE_COLS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic [2:0]          target_filter,
  input  logic [7:0]          weight_position,
  input  logic signed [15:0]  sample_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  sum_value,
  output logic [9:0]          out_row,
  output logic [5:0]          out_col,
  output logic [2:0]          out_filter,
  output logic                last_of_window,
  output logic                last_of_image
);
  import cfwd_pkg::*;

  localparam int FW    = MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
  localparam int WDEP  = MAX_FILTERS * FW;
  localparam int LDEP  = MAX_KERNEL * MAX_IMAGE_COLS * MAX_CHANNELS;
  localparam int WA_W  = (WDEP > 1) ? $clog2(WDEP) : 1;
  localparam int LA_W  = (LDEP > 1) ? $clog2(LDEP) : 1;
  localparam int F_W   = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int KI_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int COL_W = $clog2(MAX_IMAGE_COLS);
  localparam int QW    = 3 + WA_W + F_W + LA_W + 16 + 1 + KI_W + COL_W + ROW_W
                         + COL_W + 1;

  cfg_t            raw;
  cfg_t            cfg;
  logic            wr;
  logic [2:0]      idx;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  logic [QW-1:0]   q_in;
  logic [QW-1:0]   q_out;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      raw <= '{rows: 11'd8, cols: 7'd8, chans: 4'd1, krows: 3'd3, kcols: 3'd3,
               srows: 3'd1, scols: 3'd1, filters: 4'd1};
    end else if (wr) begin
      case (idx)
        REG_ROWS:    raw.rows    <= pwdata[10:0];
        REG_COLS:    raw.cols    <= pwdata[6:0];
        REG_CHANS:   raw.chans   <= pwdata[3:0];
        REG_KROWS:   raw.krows   <= pwdata[2:0];
        REG_KCOLS:   raw.kcols   <= pwdata[2:0];
        REG_SROWS:   raw.srows   <= pwdata[2:0];
        REG_SCOLS:   raw.scols   <= pwdata[2:0];
        REG_FILTERS: raw.filters <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROWS:    prdata = 32'(raw.rows);
      REG_COLS:    prdata = 32'(raw.cols);
      REG_CHANS:   prdata = 32'(raw.chans);
      REG_KROWS:   prdata = 32'(raw.krows);
      REG_KCOLS:   prdata = 32'(raw.kcols);
      REG_SROWS:   prdata = 32'(raw.srows);
      REG_SCOLS:   prdata = 32'(raw.scols);
      REG_FILTERS: prdata = 32'(raw.filters);
      default:     prdata = '0;
    endcase
  end

  // clamp each register to its usable range
  always_comb begin
    cfg = raw;
    if (raw.rows == '0) cfg.rows = 11'd1;
    else if (raw.rows > 11'd1024) cfg.rows = 11'd1024;
    if (raw.cols == '0) cfg.cols = 7'd1;
    else if (int'(raw.cols) > MAX_IMAGE_COLS) cfg.cols = 7'(MAX_IMAGE_COLS);
    if (raw.chans == '0) cfg.chans = 4'd1;
    else if (int'(raw.chans) > MAX_CHANNELS) cfg.chans = 4'(MAX_CHANNELS);
    if (raw.krows == '0) cfg.krows = 3'd1;
    else if (int'(raw.krows) > MAX_KERNEL) cfg.krows = 3'(MAX_KERNEL);
    if (raw.kcols == '0) cfg.kcols = 3'd1;
    else if (int'(raw.kcols) > MAX_KERNEL) cfg.kcols = 3'(MAX_KERNEL);
    if (raw.srows == '0) cfg.srows = 3'd1;
    else if (raw.srows > 3'd4) cfg.srows = 3'd4;
    if (raw.scols == '0) cfg.scols = 3'd1;
    else if (raw.scols > 3'd4) cfg.scols = 3'd4;
    if (raw.filters == '0) cfg.filters = 4'd1;
    else if (int'(raw.filters) > MAX_FILTERS) cfg.filters = 4'(MAX_FILTERS);
  end

  cfwd_front #(
    .MAX_FILTERS(MAX_FILTERS), .MAX_KERNEL(MAX_KERNEL),
    .MAX_CHANNELS(MAX_CHANNELS), .MAX_IMAGE_COLS(MAX_IMAGE_COLS), .QW(QW)
  ) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .restart(wr),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .target_filter(target_filter), .weight_position(weight_position),
    .sample_value(sample_value),
    .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  cfwd_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_data(q_in), .pop(q_pop),
    .pop_data(q_out), .full(q_full), .empty(q_empty)
  );

  cfwd_back #(
    .MAX_FILTERS(MAX_FILTERS), .MAX_KERNEL(MAX_KERNEL),
    .MAX_CHANNELS(MAX_CHANNELS), .MAX_IMAGE_COLS(MAX_IMAGE_COLS), .QW(QW)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .sum_value(sum_value),
    .out_row(out_row), .out_col(out_col), .out_filter(out_filter),
    .last_of_window(last_of_window), .last_of_image(last_of_image)
  );
endmodule

// ===== hdl/cfwd_queue.sv =====
// two-entry queue between the front and back parts
// depends on nothing
module cfwd_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);
  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;

  assign full     = (cnt == 2'd2);
  assign empty    = (cnt == 2'd0);
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end
endmodule

// ===== hdl/cfwd_front.sv =====
// front part: accepts items, tracks image position, finds window positions
// depends on cfwd_pkg
module cfwd_front #(
  parameter int MAX_FILTERS    = 8,
  parameter int MAX_KERNEL     = 5,
  parameter int MAX_CHANNELS   = 8,
  parameter int MAX_IMAGE_COLS = 64,
  parameter int QW             = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfwd_pkg::cfg_t        cfg,
  input  logic                  restart,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            action,
  input  logic [2:0]            target_filter,
  input  logic [7:0]            weight_position,
  input  logic signed [15:0]    sample_value,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [QW-1:0]         q_data
);
  import cfwd_pkg::*;

  localparam int FW    = MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
  localparam int WDEP  = MAX_FILTERS * FW;
  localparam int LDEP  = MAX_KERNEL * MAX_IMAGE_COLS * MAX_CHANNELS;
  localparam int WA_W  = (WDEP > 1) ? $clog2(WDEP) : 1;
  localparam int LA_W  = (LDEP > 1) ? $clog2(LDEP) : 1;
  localparam int F_W   = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int KI_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int COL_W = $clog2(MAX_IMAGE_COLS);

  typedef struct packed {
    kind_t                   kind;
    logic [WA_W-1:0]         waddr;
    logic [F_W-1:0]          fidx;
    logic [LA_W-1:0]         laddr;
    logic signed [15:0]      value;
    logic                    compute;
    logic [KI_W-1:0]         wrow;
    logic [COL_W-1:0]        wcol;
    logic [ROW_W-1:0]        orow;
    logic [COL_W-1:0]        ocol;
    logic                    last_img;
  } entry_t;

  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [CH_W-1:0]  chan;
  logic [KI_W-1:0]  lrow;
  logic [1:0]       rph;
  logic [1:0]       cph;
  logic [ROW_W-1:0] orow;
  logic [COL_W-1:0] ocol;

  logic            accept;
  logic            load_ok;
  logic            bias_ok;
  logic            ch_last;
  logic            hit;
  logic            row_end;
  logic            img_end;
  logic [10:0]     row_p1;
  logic [10:0]     col_p1;
  logic [KI_W:0]   wrow_sum;
  entry_t          e;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign bias_ok  = int'(target_filter) < MAX_FILTERS;
  assign load_ok  = bias_ok && (int'(weight_position) < FW);
  assign ch_last  = (int'(chan) + 1) >= int'(cfg.chans);
  assign row_p1   = 11'(row) + 11'd1;
  assign col_p1   = 11'(col) + 11'd1;
  assign row_end  = col_p1 >= 11'(cfg.cols);
  assign img_end  = row_p1 >= cfg.rows;
  assign hit      = (row_p1 >= 11'(cfg.krows)) && (col_p1 >= 11'(cfg.kcols))
                    && (rph == 2'd0) && (cph == 2'd0);
  assign wrow_sum = {1'b0, lrow} + (KI_W+1)'(MAX_KERNEL) - (KI_W+1)'(cfg.krows)
                    + (KI_W+1)'(1);

  always_comb begin
    e          = '0;
    e.value    = sample_value;
    e.waddr    = WA_W'(WA_W'(target_filter) * WA_W'(FW) + WA_W'(weight_position));
    e.fidx     = F_W'(target_filter);
    e.laddr    = LA_W'((LA_W'(lrow) * LA_W'(MAX_IMAGE_COLS) + LA_W'(col))
                       * LA_W'(MAX_CHANNELS) + LA_W'(chan));
    e.compute  = ch_last && hit;
    e.wrow     = (int'(wrow_sum) >= MAX_KERNEL) ? KI_W'(int'(wrow_sum) - MAX_KERNEL)
                                                : KI_W'(wrow_sum);
    e.wcol     = col - COL_W'(cfg.kcols) + COL_W'(1);
    e.orow     = orow;
    e.ocol     = ocol;
    e.last_img = (11'(row) + 11'(cfg.srows) >= cfg.rows)
                 && (11'(col) + 11'(cfg.scols) >= 11'(cfg.cols));
    case (action)
      ACT_WEIGHT: e.kind = K_WEIGHT;
      ACT_BIAS:   e.kind = K_BIAS;
      default:    e.kind = K_PIXEL;
    endcase
  end

  always_comb begin
    q_push = 1'b0;
    case (action)
      ACT_WEIGHT: q_push = accept && load_ok;
      ACT_BIAS:   q_push = accept && bias_ok;
      ACT_PIXEL:  q_push = accept;
      default:    q_push = 1'b0;
    endcase
  end

  assign q_data = QW'(e);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row  <= '0;
      col  <= '0;
      chan <= '0;
      lrow <= '0;
      rph  <= '0;
      cph  <= '0;
      orow <= '0;
      ocol <= '0;
    end else if (accept && action == ACT_PIXEL) begin
      if (!ch_last) begin
        chan <= chan + CH_W'(1);
      end else begin
        chan <= '0;
        if (row_end) begin
          col  <= '0;
          cph  <= '0;
          ocol <= '0;
          if (img_end) begin
            row  <= '0;
            lrow <= '0;
            rph  <= '0;
            orow <= '0;
          end else begin
            row  <= row + ROW_W'(1);
            lrow <= (int'(lrow) == MAX_KERNEL - 1) ? '0 : lrow + KI_W'(1);
            if (row_p1 + 11'd1 <= 11'(cfg.krows)) begin
              rph  <= '0;
              orow <= '0;
            end else if (rph == 2'(cfg.srows - 3'd1)) begin
              rph  <= '0;
              orow <= orow + ROW_W'(1);
            end else begin
              rph <= rph + 2'd1;
            end
          end
        end else begin
          col <= col + COL_W'(1);
          if (col_p1 + 11'd1 <= 11'(cfg.kcols)) begin
            cph  <= '0;
            ocol <= '0;
          end else if (cph == 2'(cfg.scols - 3'd1)) begin
            cph  <= '0;
            ocol <= ocol + COL_W'(1);
          end else begin
            cph <= cph + 2'd1;
          end
        end
      end
    end
  end
endmodule

// ===== hdl/cfwd_back.sv =====
// back part: weight, bias and line stores, shared multiply-accumulate, result queue
// depends on cfwd_pkg
module cfwd_back #(
  parameter int MAX_FILTERS    = 8,
  parameter int MAX_KERNEL     = 5,
  parameter int MAX_CHANNELS   = 8,
  parameter int MAX_IMAGE_COLS = 64,
  parameter int QW             = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfwd_pkg::cfg_t       cfg,
  input  logic                 q_empty,
  input  logic [QW-1:0]        q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   sum_value,
  output logic [9:0]           out_row,
  output logic [5:0]           out_col,
  output logic [2:0]           out_filter,
  output logic                 last_of_window,
  output logic                 last_of_image
);
  import cfwd_pkg::*;

  localparam int FW    = MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
  localparam int WDEP  = MAX_FILTERS * FW;
  localparam int LDEP  = MAX_KERNEL * MAX_IMAGE_COLS * MAX_CHANNELS;
  localparam int WA_W  = (WDEP > 1) ? $clog2(WDEP) : 1;
  localparam int LA_W  = (LDEP > 1) ? $clog2(LDEP) : 1;
  localparam int F_W   = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int KI_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int COL_W = $clog2(MAX_IMAGE_COLS);
  localparam int ACC_W = 34 + $clog2(FW + 1);
  localparam int RP_W  = $clog2(RES_DEPTH);

  typedef struct packed {
    kind_t                   kind;
    logic [WA_W-1:0]         waddr;
    logic [F_W-1:0]          fidx;
    logic [LA_W-1:0]         laddr;
    logic signed [15:0]      value;
    logic                    compute;
    logic [KI_W-1:0]         wrow;
    logic [COL_W-1:0]        wcol;
    logic [ROW_W-1:0]        orow;
    logic [COL_W-1:0]        ocol;
    logic                    last_img;
  } entry_t;

  typedef struct packed {
    logic               v;
    logic               first;
    logic               last;
    logic [F_W-1:0]     f;
    logic signed [15:0] bias;
    logic               lw;
    logic               li;
    logic [ROW_W-1:0]   orow;
    logic [COL_W-1:0]   ocol;
  } tag_t;

  typedef struct packed {
    logic signed [31:0] sum;
    logic [ROW_W-1:0]   orow;
    logic [COL_W-1:0]   ocol;
    logic [F_W-1:0]     f;
    logic               lw;
    logic               li;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  logic signed [15:0] wmem [WDEP];
  logic signed [15:0] lmem [LDEP];
  logic signed [15:0] bmem [MAX_FILTERS];
  logic signed [15:0] wrd;
  logic signed [15:0] lrd;

  state_t            st;
  entry_t            e;
  logic [F_W-1:0]    f;
  logic [2:0]        m;
  logic [2:0]        k;
  logic [CH_W-1:0]   c;
  logic [KI_W-1:0]   lrow;
  logic [KI_W-1:0]   wrow_j;
  logic [COL_W-1:0]  wcol_j;
  logic [WA_W-1:0]   wa;
  logic [WA_W-1:0]   wbase;
  logic [WA_W-1:0]   wbase_next;
  logic [ROW_W-1:0]  orow_j;
  logic [COL_W-1:0]  ocol_j;
  logic              li_j;

  logic              c_end;
  logic              k_end;
  logic              m_end;
  logic              f_end;
  logic              step_last;
  logic              room;
  logic              issue;
  logic [LA_W-1:0]   la_rd;
  tag_t              t0;
  tag_t              p1;
  tag_t              p2;
  logic signed [31:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] sum;
  logic signed [31:0]      sat;
  logic                    ovf_pos;
  logic                    ovf_neg;

  res_t              rq [RES_DEPTH];
  logic [RP_W-1:0]   rq_wp;
  logic [RP_W-1:0]   rq_rp;
  logic [RP_W:0]     rq_cnt;
  logic              rq_push;
  logic              rq_pop;
  res_t              rq_head;

  assign e     = entry_t'(q_data);
  assign q_pop = (st == S_IDLE) && !q_empty;

  assign c_end     = (int'(c) + 1) == int'(cfg.chans);
  assign k_end     = k == (cfg.kcols - 3'd1);
  assign m_end     = m == (cfg.krows - 3'd1);
  assign f_end     = (int'(f) + 1) == int'(cfg.filters);
  assign step_last = c_end && k_end && m_end;
  assign room      = (int'(rq_cnt) + int'(p1.v && p1.last) + int'(p2.v && p2.last))
                     < RES_DEPTH;
  assign issue     = (st == S_RUN) && (!step_last || room);
  assign la_rd     = LA_W'((LA_W'(lrow) * LA_W'(MAX_IMAGE_COLS) + LA_W'(wcol_j)
                           + LA_W'(k)) * LA_W'(MAX_CHANNELS) + LA_W'(c));
  assign wbase_next = WA_W'(wbase + WA_W'(FW));

  always_comb begin
    t0       = '0;
    t0.v     = issue;
    t0.first = (m == 3'd0) && (k == 3'd0) && (c == '0);
    t0.last  = step_last;
    t0.f     = f;
    t0.bias  = bmem[f];
    t0.lw    = f_end;
    t0.li    = f_end && li_j;
    t0.orow  = orow_j;
    t0.ocol  = ocol_j;
  end

  always_ff @(posedge clk) begin
    if (q_pop && e.kind == K_WEIGHT) begin
      wmem[e.waddr] <= e.value;
    end
    wrd <= wmem[wa];
  end

  always_ff @(posedge clk) begin
    if (q_pop && e.kind == K_PIXEL) begin
      lmem[e.laddr] <= e.value;
    end
    lrd <= lmem[la_rd];
  end

  always_ff @(posedge clk) begin
    if (q_pop && e.kind == K_BIAS) begin
      bmem[e.fidx] <= e.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      case (st)
        S_IDLE: begin
          if (q_pop && e.kind == K_PIXEL && e.compute) begin
            st     <= S_RUN;
            f      <= '0;
            m      <= '0;
            k      <= '0;
            c      <= '0;
            lrow   <= e.wrow;
            wrow_j <= e.wrow;
            wcol_j <= e.wcol;
            wa     <= '0;
            wbase  <= '0;
            orow_j <= e.orow;
            ocol_j <= e.ocol;
            li_j   <= e.last_img;
          end
        end
        S_RUN: begin
          if (issue) begin
            if (c_end) begin
              c <= '0;
              if (k_end) begin
                k <= '0;
                if (m_end) begin
                  m     <= '0;
                  lrow  <= wrow_j;
                  wa    <= wbase_next;
                  wbase <= wbase_next;
                  if (f_end) st <= S_IDLE;
                  else f <= f + F_W'(1);
                end else begin
                  m    <= m + 3'd1;
                  lrow <= (int'(lrow) == MAX_KERNEL - 1) ? '0 : lrow + KI_W'(1);
                  wa   <= wa + WA_W'(1);
                end
              end else begin
                k  <= k + 3'd1;
                wa <= wa + WA_W'(1);
              end
            end else begin
              c  <= c + CH_W'(1);
              wa <= wa + WA_W'(1);
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1.v <= 1'b0;
      p2.v <= 1'b0;
    end else begin
      p1 <= t0;
      p2 <= p1;
    end
    prod <= lrd * wrd;
  end

  always_comb begin
    sum = (p2.first ? {{(ACC_W-24){p2.bias[15]}}, p2.bias, 8'h00} : acc)
          + {{(ACC_W-32){prod[31]}}, prod};
    ovf_pos = !sum[ACC_W-1] && (|sum[ACC_W-2:31]);
    ovf_neg = sum[ACC_W-1] && !(&sum[ACC_W-2:31]);
    if (ovf_pos) sat = 32'sh7fffffff;
    else if (ovf_neg) sat = 32'sh80000000;
    else sat = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (p2.v) acc <= sum;
  end

  assign rq_push   = p2.v && p2.last;
  assign rq_pop    = out_valid && out_ready;
  assign rq_head   = rq[rq_rp];
  assign out_valid = rq_cnt != '0;

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq[rq_wp] <= '{sum: sat, orow: p2.orow, ocol: p2.ocol, f: p2.f,
                     lw: p2.lw, li: p2.li};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wp  <= '0;
      rq_rp  <= '0;
      rq_cnt <= '0;
    end else begin
      if (rq_push) rq_wp <= rq_wp + RP_W'(1);
      if (rq_pop) rq_rp <= rq_rp + RP_W'(1);
      if (rq_push && !rq_pop) rq_cnt <= rq_cnt + (RP_W+1)'(1);
      else if (rq_pop && !rq_push) rq_cnt <= rq_cnt - (RP_W+1)'(1);
    end
  end

  assign sum_value      = rq_head.sum;
  assign out_row        = rq_head.orow;
  assign out_col        = OUT_COL_W'(rq_head.ocol);
  assign out_filter     = 3'(rq_head.f);
  assign last_of_window = rq_head.lw;
  assign last_of_image  = rq_head.li;
endmodule

// ===== hdl/cfwd_checker.sv =====
// port-level checks of the convolution block, bound to the top level
// no dependencies
module cfwd_checker (
  input logic               clk,
  input logic               rst,
  input logic               pready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] sum_value,
  input logic               last_of_window,
  input logic               last_of_image
);
  a_image_end_closes_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_image |-> last_of_window)
    else $error("last_of_image without last_of_window");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sum_value))
    else $error("stalled result changed");

  a_pready_high: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");
endmodule

bind conv2d_forward_top cfwd_checker u_cfwd_checker (.*);

// ===== tb/tb_top.sv =====
// self-checking testbench of conv2d_forward_top: directed table, then random phases
// predicts every result word in its own convolution model; depends on cfwd_pkg and the RTL
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cfwd_pkg::*;

  localparam int FW = 200;

  typedef struct {
    logic signed [31:0] sum;
    logic [9:0]         row;
    logic [5:0]         col;
    logic [2:0]         filt;
    logic               low;
    logic               loi;
  } res_t;

  typedef struct {
    logic [1:0]         act;
    logic [2:0]         tf;
    logic [7:0]         pos;
    logic signed [15:0] val;
    bit                 typed;
    int                 sum;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = '0;
  logic [2:0] target_filter = '0;
  logic [7:0] weight_position = '0;
  logic signed [15:0] sample_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] sum_value;
  logic [9:0] out_row;
  logic [5:0] out_col;
  logic [2:0] out_filter;
  logic last_of_window, last_of_image;

  conv2d_forward_top i_dut (.*);

  always #2 clk = ~clk;

  cfg_t cfg;
  logic signed [15:0] wmem [0:1599];
  logic signed [15:0] bmem [0:7];
  logic signed [15:0] lmem [0:2559];
  bit wok [0:1599];
  bit bok [0:7];
  int row_cnt, col_cnt, ch_cnt;
  res_t sums_q[$];
  int err_cnt = 0;
  bit quiet = 0;
  bit hold_req = 0;

  function automatic int clampu(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic conv_predict(input logic [1:0] a, input logic [2:0] tf, input logic [7:0] pos,
                              input logic signed [15:0] v);
    int nr, nc, nch, kr, kc, sr, sc, nf, r, c, wr, wc, orow, ocol;
    bit lim;
    longint acc;
    res_t e;
    nr = clampu(cfg.rows, 1, 1024);
    nc = clampu(cfg.cols, 1, 64);
    nch = clampu(cfg.chans, 1, 8);
    kr = clampu(cfg.krows, 1, 5);
    kc = clampu(cfg.kcols, 1, 5);
    sr = clampu(cfg.srows, 1, 4);
    sc = clampu(cfg.scols, 1, 4);
    nf = clampu(cfg.filters, 1, 8);
    if (a == ACT_WEIGHT) begin
      if (pos < FW) begin
        wmem[tf*FW+pos] = v;
        wok[tf*FW+pos] = 1;
      end
    end else if (a == ACT_BIAS) begin
      bmem[tf] = v;
      bok[tf] = 1;
    end else if (a == ACT_PIXEL) begin
      r = row_cnt >= nr ? 0 : row_cnt;
      c = col_cnt >= nc ? 0 : col_cnt;
      if (ch_cnt >= nch) ch_cnt = 0;
      lmem[((r % 5) * 64 + c) * 8 + ch_cnt] = v;
      if (ch_cnt + 1 < nch) begin
        ch_cnt++;
        return;
      end
      ch_cnt = 0;
      if (r + 1 >= kr && c + 1 >= kc && (r + 1 - kr) % sr == 0 && (c + 1 - kc) % sc == 0) begin
        wr = r + 1 - kr;
        wc = c + 1 - kc;
        orow = wr / sr;
        ocol = wc / sc;
        lim = orow == (nr - kr) / sr && ocol == (nc - kc) / sc;
        for (int f = 0; f < nf; f++) begin
          acc = longint'(bmem[f]) * 256;
          for (int m = 0; m < kr; m++)
            for (int k = 0; k < kc; k++)
              for (int ch = 0; ch < nch; ch++)
                acc += longint'(lmem[(((wr + m) % 5) * 64 + wc + k) * 8 + ch]) *
                       longint'(wmem[f*FW + (m*kc + k)*nch + ch]);
          if (acc > 64'sd2147483647) acc = 64'sd2147483647;
          if (acc < -64'sd2147483648) acc = -64'sd2147483648;
          e.sum = acc[31:0];
          e.row = 10'(orow);
          e.col = 6'(ocol);
          e.filt = 3'(f);
          e.low = f + 1 == nf;
          e.loi = f + 1 == nf && lim;
          sums_q.push_back(e);
        end
      end
      c++;
      if (c >= nc) begin
        c = 0;
        r++;
        if (r >= nr) r = 0;
      end
      row_cnt = r;
      col_cnt = c;
    end
  endtask

  function automatic int gap_len();
    int d;
    d = $urandom_range(0, 99);
    if (quiet || d < 60) return 0;
    if (d < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input logic [1:0] a, input logic [2:0] tf, input logic [7:0] pos,
                           input logic signed [15:0] v);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= a;
    target_filter <= tf;
    weight_position <= pos;
    sample_value <= v;
    do @(posedge clk); while (!in_ready);
    conv_predict(a, tf, pos, v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sums_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input int v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ROWS:    cfg.rows = 11'(v);
      REG_COLS:    cfg.cols = 7'(v);
      REG_CHANS:   cfg.chans = 4'(v);
      REG_KROWS:   cfg.krows = 3'(v);
      REG_KCOLS:   cfg.kcols = 3'(v);
      REG_SROWS:   cfg.srows = 3'(v);
      REG_SCOLS:   cfg.scols = 3'(v);
      REG_FILTERS: cfg.filters = 4'(v);
      default: ;
    endcase
    row_cnt = 0;
    col_cnt = 0;
    ch_cnt = 0;
  endtask

  task automatic write_cfg(input int p[10]);
    reg_write(REG_ROWS, p[0]);
    reg_write(REG_COLS, p[1]);
    reg_write(REG_CHANS, p[2]);
    reg_write(REG_KROWS, p[3]);
    reg_write(REG_KCOLS, p[4]);
    reg_write(REG_SROWS, p[5]);
    reg_write(REG_SCOLS, p[6]);
    reg_write(REG_FILTERS, p[7]);
  endtask

  task automatic check_word();
    res_t e;
    if (sums_q.size() == 0) begin
      $display("%0t: unexpected word sum %0d row %0d col %0d", $time, sum_value, out_row,
               out_col);
      err_cnt++;
      return;
    end
    e = sums_q.pop_front();
    if (sum_value !== e.sum || out_row !== e.row || out_col !== e.col ||
        out_filter !== e.filt || last_of_window !== e.low || last_of_image !== e.loi) begin
      $display("%0t: mismatch exp sum %0d row %0d col %0d filt %0d low %0b loi %0b", $time,
               e.sum, e.row, e.col, e.filt, e.low, e.loi);
      $display("%0t:          got sum %0d row %0d col %0d filt %0d low %0b loi %0b", $time,
               sum_value, out_row, out_col, out_filter, last_of_window, last_of_image);
      err_cnt++;
    end
  endtask

  // rows, cols, chans, krows, kcols, srows, scols, filters, samples, extreme
  int phases [8][10] = '{
    '{8, 8, 1, 3, 3, 1, 1, 1, 36, 0},
    '{2047, 3, 2, 2, 2, 1, 1, 3, 32, 0},
    '{9, 5, 1, 7, 7, 4, 4, 0, 45, 1},
    '{0, 127, 15, 1, 1, 7, 7, 2, 32, 0},
    '{6, 7, 3, 2, 3, 2, 3, 4, 70, 0},
    '{4, 2, 1, 3, 3, 1, 1, 2, 20, 0},
    '{5, 4, 1, 2, 2, 1, 1, 8, 48, 0},
    '{3, 3, 0, 0, 0, 0, 0, 15, 30, 0}
  };

  row_t dir_tbl [15] = '{
    '{ACT_WEIGHT, 0, 0, 16'sh0100, 0, 0},
    '{ACT_BIAS, 0, 0, 16'sh0000, 0, 0},
    '{ACT_PIXEL, 0, 0, 16'sh0100, 1, 65536},
    '{ACT_PIXEL, 0, 0, 16'sh7fff, 1, 8388352},
    '{ACT_PIXEL, 0, 0, 16'sh8000, 1, -8388608},
    '{ACT_WEIGHT, 0, 0, 16'sh8000, 0, 0},
    '{ACT_PIXEL, 0, 0, 16'sh8000, 1, 1073741824},
    '{ACT_BIAS, 0, 0, 16'sh7fff, 0, 0},
    '{ACT_PIXEL, 0, 0, 16'sh8000, 1, 1082130176},
    '{ACT_BIAS, 0, 0, 16'sh8000, 0, 0},
    '{ACT_PIXEL, 0, 0, 16'sh7fff, 1, -1082097664},
    '{2'd3, 7, 8'hff, 16'shffff, 0, 0},
    '{ACT_WEIGHT, 7, 8'hff, 16'sh7fff, 0, 0},
    '{ACT_WEIGHT, 5, 8'd200, 16'sh1234, 0, 0},
    '{ACT_PIXEL, 0, 0, 16'sh0000, 1, -8388608}
  };

  initial begin
    int p[10];
    int need, nf, d;
    logic signed [15:0] v;
    cfg = '{rows: 8, cols: 8, chans: 1, krows: 3, kcols: 3, srows: 1, scols: 1, filters: 1};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_cfg('{2, 2, 1, 1, 1, 1, 1, 1, 0, 0});
    foreach (dir_tbl[i]) begin
      send_word(dir_tbl[i].act, dir_tbl[i].tf, dir_tbl[i].pos, dir_tbl[i].val);
      if (dir_tbl[i].typed && sums_q.size() != 0) sums_q[$].sum = dir_tbl[i].sum;
    end
    drain();
    foreach (phases[ph]) begin
      p = phases[ph];
      quiet = ph % 3 == 2;
      write_cfg(p);
      nf = clampu(cfg.filters, 1, 8);
      need = clampu(cfg.krows, 1, 5) * clampu(cfg.kcols, 1, 5) * clampu(cfg.chans, 1, 8);
      for (int f = 0; f < nf; f++) begin
        for (int k = 0; k < need; k++)
          if (!wok[f*FW+k] || p[9])
            send_word(ACT_WEIGHT, 3'(f), 8'(k),
                      p[9] ? 16'sh8000 : 16'($urandom_range(0, 65535)));
        if (!bok[f] || p[9])
          send_word(ACT_BIAS, 3'(f), 8'd0,
                    p[9] ? 16'sh7fff : 16'($urandom_range(0, 65535)));
      end
      if (ph == 6) hold_req = 1;
      for (int n = 0; n < p[8]; n++) begin
        if (ph == 4 && n == 60) begin
          in_valid <= 1'b0;
          while (sums_q.size() != 0) @(posedge clk);
        end
        d = $urandom_range(0, 99);
        if (d < 6 && !p[9])
          send_word(ACT_WEIGHT, 3'($urandom_range(0, nf - 1)), 8'($urandom_range(0, need - 1)),
                    16'($urandom_range(0, 65535)));
        else if (d < 9 && !p[9])
          send_word(ACT_BIAS, 3'($urandom_range(0, nf - 1)), 8'd0,
                    16'($urandom_range(0, 65535)));
        else if (d < 11)
          send_word(2'd3, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)));
        else if (d < 13)
          send_word(ACT_WEIGHT, 3'($urandom_range(0, 7)), 8'($urandom_range(200, 255)),
                    16'($urandom_range(0, 65535)));
        if (p[9]) v = row_cnt < 5 ? 16'sh8000 : 16'sh7fff;
        else if (d > 90) v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        else v = 16'($urandom_range(0, 65535));
        send_word(ACT_PIXEL, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), v);
      end
      drain();
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_word();
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (2000) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 199) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(30, 80)) @(posedge clk);
      end else begin
        out_ready <= quiet || $urandom_range(0, 9) > 2;
      end
    end
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
